// ===== design/tsmt_pkg.sv =====
// Package for the two-set membership table.
// Holds field widths, command and status codes and the per-cell control word.
// No dependencies.
package tsmt_pkg;

    localparam int DATA_W    = 31;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int DEPTH_DEF = 32;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ISECT  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ISECT_ELEM  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ISECT_EMPTY = 3'd6;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic sh_a;
        logic sh_b;
    } cell_ctl_t;

endpackage

// ===== design/two_set_membership_table.sv =====
// Top level of the two-set membership table: command sequencer, output register
// and the row of tsmt_cell entries. Depends on tsmt_pkg and tsmt_cell.
//
// channel | dir | tdata                    | tuser                          | tlast
// s_      | in  | [30:0] value             | [1:0] command, [2] set_select  | -
// m_      | out | [30:0] element           | [2:0] status                   | last
//
// Add, check and delete go through these steps for each word: accept, register the cell compares, act.
// Intersect scans set A entry by entry, with a compare step and an act step for each entry.
// s_tready is high only while idle. A result waits in the output register while
// m_tready is low; the sequencer holds until the register is free.
// Reset clears counts and control only; entries need no clearing.
module two_set_membership_table #(
    parameter int DEPTH = tsmt_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value, [31] zero
    input  logic [2:0]  s_tuser,   // [1:0] command, [2] set_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] element, [31] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = tsmt_pkg::DATA_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [tsmt_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic                          sel_reg, sel_next;
    logic [DW-1:0]                 val_reg, val_next;
    logic [CW-1:0]                 count_a_reg, count_a_next;
    logic [CW-1:0]                 count_b_reg, count_b_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [DW-1:0]                 pend_elem_reg, pend_elem_next;
    logic                          out_valid_reg, out_valid_next;
    logic [tsmt_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [DW-1:0]                 out_elem_reg, out_elem_next;
    logic                          out_last_reg, out_last_next;

    logic [DW-1:0]    a_vec [DEPTH];
    logic [DW-1:0]    b_vec [DEPTH];
    logic [DEPTH-1:0] hit_a_vec, hit_b_vec;
    logic [DEPTH-1:0] ge_a, ge_b;
    logic [DW-1:0]    cand;
    logic [CW-1:0]    lim_a;
    logic             is_isect, slot_free, sel_hit, new_elem;
    logic             do_add_a, do_add_b, do_del_a, do_del_b;
    logic [CW-1:0]    sel_count;

    tsmt_pkg::cell_ctl_t ctl [DEPTH];

    assign is_isect  = (cmd_reg == tsmt_pkg::CMD_ISECT);
    assign cand      = is_isect ? a_vec[idx_reg[IW-1:0]] : val_reg;
    assign lim_a     = is_isect ? idx_reg : count_a_reg;
    assign slot_free = !out_valid_reg || m_tready;
    assign sel_hit   = sel_reg ? (|hit_b_vec) : (|hit_a_vec);
    assign sel_count = sel_reg ? count_b_reg : count_a_reg;
    assign new_elem  = !(|hit_a_vec) && (|hit_b_vec);

    // entries at and above the first match shift down
    assign ge_a = ~((hit_a_vec & (~hit_a_vec + DEPTH'(1))) - DEPTH'(1));
    assign ge_b = ~((hit_b_vec & (~hit_b_vec + DEPTH'(1))) - DEPTH'(1));

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        sel_next        = sel_reg;
        val_next        = val_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_elem_next  = pend_elem_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_last_next   = out_last_reg;
        do_add_a        = 1'b0;
        do_add_b        = 1'b0;
        do_del_a        = 1'b0;
        do_del_b        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = s_tuser[1:0];
                    sel_next        = s_tuser[2];
                    val_next        = s_tdata[DW-1:0];
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_RES;
            end
            S_RES: begin
                case (cmd_reg)
                    tsmt_pkg::CMD_ADD: begin
                        if (slot_free) begin
                            out_valid_next = 1'b1;
                            out_elem_next  = val_reg;
                            out_last_next  = 1'b1;
                            if (sel_count == CW'(DEPTH)) begin
                                out_status_next = tsmt_pkg::ST_FULL;
                            end else begin
                                out_status_next = tsmt_pkg::ST_ADDED;
                                do_add_a        = !sel_reg;
                                do_add_b        = sel_reg;
                                if (sel_reg) begin
                                    count_b_next = count_b_reg + CW'(1);
                                end else begin
                                    count_a_next = count_a_reg + CW'(1);
                                end
                            end
                            state_next = S_IDLE;
                        end
                    end
                    tsmt_pkg::CMD_CHECK: begin
                        if (slot_free) begin
                            out_valid_next  = 1'b1;
                            out_elem_next   = val_reg;
                            out_last_next   = 1'b1;
                            out_status_next = sel_hit ? tsmt_pkg::ST_PRESENT
                                                      : tsmt_pkg::ST_ABSENT;
                            state_next      = S_IDLE;
                        end
                    end
                    tsmt_pkg::CMD_DELETE: begin
                        if (slot_free) begin
                            out_valid_next = 1'b1;
                            out_elem_next  = val_reg;
                            out_last_next  = 1'b1;
                            if (sel_hit) begin
                                out_status_next = tsmt_pkg::ST_DELETED;
                                do_del_a        = !sel_reg;
                                do_del_b        = sel_reg;
                                if (sel_reg) begin
                                    count_b_next = count_b_reg - CW'(1);
                                end else begin
                                    count_a_next = count_a_reg - CW'(1);
                                end
                            end else begin
                                out_status_next = tsmt_pkg::ST_ABSENT;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    tsmt_pkg::CMD_ISECT: begin
                        if (idx_reg >= count_a_reg) begin
                            if (slot_free) begin
                                out_valid_next = 1'b1;
                                out_last_next  = 1'b1;
                                if (pend_valid_reg) begin
                                    out_status_next = tsmt_pkg::ST_ISECT_ELEM;
                                    out_elem_next   = pend_elem_reg;
                                end else begin
                                    out_status_next = tsmt_pkg::ST_ISECT_EMPTY;
                                    out_elem_next   = val_reg;
                                end
                                state_next = S_IDLE;
                            end
                        end else if (new_elem && pend_valid_reg) begin
                            if (slot_free) begin
                                out_valid_next  = 1'b1;
                                out_last_next   = 1'b0;
                                out_status_next = tsmt_pkg::ST_ISECT_ELEM;
                                out_elem_next   = pend_elem_reg;
                                pend_elem_next  = cand;
                                idx_next        = idx_reg + CW'(1);
                                state_next      = S_CMP;
                            end
                        end else begin
                            if (new_elem) begin
                                pend_valid_next = 1'b1;
                                pend_elem_next  = cand;
                            end
                            idx_next   = idx_reg + CW'(1);
                            state_next = S_CMP;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic [DW-1:0] up_a, up_b;

        if (j < DEPTH - 1) begin : g_mid
            assign up_a = a_vec[j+1];
            assign up_b = b_vec[j+1];
        end else begin : g_top
            assign up_a = a_vec[j];
            assign up_b = b_vec[j];
        end

        assign ctl[j].wr_a = do_add_a && (count_a_reg == CW'(j));
        assign ctl[j].wr_b = do_add_b && (count_b_reg == CW'(j));
        assign ctl[j].sh_a = do_del_a && ge_a[j];
        assign ctl[j].sh_b = do_del_b && ge_b[j];

        tsmt_cell #(
            .DEPTH (DEPTH),
            .INDEX (j)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (ctl[j]),
            .wr_data (val_reg),
            .cand    (cand),
            .lim_a   (lim_a),
            .lim_b   (count_b_reg),
            .next_a  (up_a),
            .next_b  (up_b),
            .a_q     (a_vec[j]),
            .b_q     (b_vec[j]),
            .hit_a   (hit_a_vec[j]),
            .hit_b   (hit_b_vec[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        sel_reg        <= sel_next;
        val_reg        <= val_next;
        pend_elem_reg  <= pend_elem_next;
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_last_reg   <= out_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_elem_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_a_reg <= CW'(DEPTH)) && (count_b_reg <= CW'(DEPTH)))
        else $error("set count beyond depth");

    a_isect_keeps_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && is_isect) |=> $stable(count_a_reg) && $stable(count_b_reg))
        else $error("set changed during intersect");

    a_isect_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && is_isect) |-> (idx_reg <= count_a_reg))
        else $error("intersect scan beyond set A");

    a_idle_no_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_RES && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced outside result state");
`endif

endmodule

// ===== design/tsmt_cell.sv =====
// One cell of the table: one entry of set A and one of set B, with its match flags.
// Takes the shifted entry from the next cell up on delete.
// Depends on tsmt_pkg.
module tsmt_cell #(
    parameter int DEPTH = tsmt_pkg::DEPTH_DEF,
    parameter int INDEX = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  tsmt_pkg::cell_ctl_t         ctl,
    input  logic [tsmt_pkg::DATA_W-1:0] wr_data,
    input  logic [tsmt_pkg::DATA_W-1:0] cand,
    input  logic [CW-1:0]               lim_a,
    input  logic [CW-1:0]               lim_b,
    input  logic [tsmt_pkg::DATA_W-1:0] next_a,
    input  logic [tsmt_pkg::DATA_W-1:0] next_b,
    output logic [tsmt_pkg::DATA_W-1:0] a_q,
    output logic [tsmt_pkg::DATA_W-1:0] b_q,
    output logic                        hit_a,
    output logic                        hit_b
);

    logic [tsmt_pkg::DATA_W-1:0] a_reg, a_next;
    logic [tsmt_pkg::DATA_W-1:0] b_reg, b_next;
    logic                        hit_a_reg, hit_a_next;
    logic                        hit_b_reg, hit_b_next;

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        if (ctl.wr_a) begin
            a_next = wr_data;
        end else if (ctl.sh_a) begin
            a_next = next_a;
        end
        if (ctl.wr_b) begin
            b_next = wr_data;
        end else if (ctl.sh_b) begin
            b_next = next_b;
        end
        hit_a_next = (a_reg == cand) && (lim_a > CW'(INDEX));
        hit_b_next = (b_reg == cand) && (lim_b > CW'(INDEX));
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        hit_a_reg <= hit_a_next;
        hit_b_reg <= hit_b_next;
    end

    assign a_q   = a_reg;
    assign b_q   = b_reg;
    assign hit_a = hit_a_reg;
    assign hit_b = hit_b_reg;

endmodule

// ===== tb/tb_two_set_membership_table.sv =====
// Testbench for two_set_membership_table: directed, fill-to-full and random command streams.
// Expected replies come from an in-bench model of both sets and are compared word by word.
// Depends on tsmt_pkg and the two_set_membership_table RTL.
module tb_two_set_membership_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = tsmt_pkg::DEPTH_DEF;
    localparam int DRAIN       = 2 * DEPTH + 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [tsmt_pkg::STATUS_W-1:0] status;
        logic [tsmt_pkg::DATA_W-1:0]   element;
        logic                          last;
    } reply_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [30:0] value, [31] zero
    logic [2:0]  s_tuser  = '0;   // [1:0] command, [2] set_select
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [30:0] element, [31] zero
    logic [2:0]  m_tuser;         // [2:0] status
    logic        m_tlast;

    logic [tsmt_pkg::DATA_W-1:0] set_mem [2][DEPTH];
    int                          set_len [2];
    reply_t                      due_replies [$];
    reply_t                      want;

    int mismatches    = 0;
    int words_sent    = 0;
    int replies_seen  = 0;
    int common_seen   = 0;
    int full_seen     = 0;
    int burst_left    = 0;
    int cycle_count   = 0;

    logic [6:0] ready_phase = '0;
    logic [1:0] ready_mode  = '0;

    two_set_membership_table #(.DEPTH(DEPTH)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        ready_phase <= ready_phase + 7'd1;
        if (ready_phase == '0) begin
            ready_mode <= 2'($urandom_range(3));
        end
        case (ready_mode)
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= ($urandom_range(3) != 0);
            end
            2'd2: begin
                m_tready <= (ready_phase[2:0] == 3'd0);
            end
            default: begin
                m_tready <= ($urandom_range(1) == 0);
            end
        endcase
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        $display("mismatch on reply %0d: %s got %h want %h", replies_seen, what, got, exp_val);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_replies.size() == 0) begin
                report_mismatch("word with nothing due", m_tdata, '0);
            end else begin
                want = due_replies.pop_front();
                if (m_tuser != want.status) begin
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                end
                if (m_tdata != {1'b0, want.element}) begin
                    report_mismatch("element", m_tdata, {1'b0, want.element});
                end
                if (m_tlast != want.last) begin
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
                if (want.status == tsmt_pkg::ST_ISECT_ELEM) begin
                    common_seen++;
                end
                if (want.status == tsmt_pkg::ST_FULL) begin
                    full_seen++;
                end
            end
            replies_seen++;
        end
    end

    function automatic int find_first(input int sel, input int n,
                                      input logic [tsmt_pkg::DATA_W-1:0] val);
        for (int i = 0; i < n; i++) begin
            if (set_mem[sel][i] == val) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic model_command(input logic [tsmt_pkg::CMD_W-1:0] cmd, input logic sel,
                                 input logic [tsmt_pkg::DATA_W-1:0] val);
        int                          n;
        int                          pos;
        int                          s;
        logic [tsmt_pkg::DATA_W-1:0] common [$];
        s = int'(sel);
        n = set_len[s];
        case (cmd)
            tsmt_pkg::CMD_ADD: begin
                if (n >= DEPTH) begin
                    due_replies.push_back('{tsmt_pkg::ST_FULL, val, 1'b1});
                end else begin
                    set_mem[s][n] = val;
                    set_len[s]    = n + 1;
                    due_replies.push_back('{tsmt_pkg::ST_ADDED, val, 1'b1});
                end
            end
            tsmt_pkg::CMD_CHECK: begin
                if (find_first(s, n, val) >= 0) begin
                    due_replies.push_back('{tsmt_pkg::ST_PRESENT, val, 1'b1});
                end else begin
                    due_replies.push_back('{tsmt_pkg::ST_ABSENT, val, 1'b1});
                end
            end
            tsmt_pkg::CMD_DELETE: begin
                pos = find_first(s, n, val);
                if (pos < 0) begin
                    due_replies.push_back('{tsmt_pkg::ST_ABSENT, val, 1'b1});
                end else begin
                    for (int i = pos; i < n - 1; i++) begin
                        set_mem[s][i] = set_mem[s][i + 1];
                    end
                    set_len[s] = n - 1;
                    due_replies.push_back('{tsmt_pkg::ST_DELETED, val, 1'b1});
                end
            end
            default: begin
                for (int i = 0; i < set_len[0]; i++) begin
                    if (find_first(0, i, set_mem[0][i]) < 0 &&
                        find_first(1, set_len[1], set_mem[0][i]) >= 0) begin
                        common.push_back(set_mem[0][i]);
                    end
                end
                if (common.size() == 0) begin
                    due_replies.push_back('{tsmt_pkg::ST_ISECT_EMPTY, val, 1'b1});
                end else begin
                    foreach (common[j]) begin
                        due_replies.push_back('{tsmt_pkg::ST_ISECT_ELEM, common[j],
                                                logic'(j == common.size() - 1)});
                    end
                end
            end
        endcase
    endtask

    task automatic send_word(input logic [tsmt_pkg::CMD_W-1:0] cmd, input logic sel,
                             input logic [tsmt_pkg::DATA_W-1:0] val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, cmd};
        s_tdata  <= {1'b0, val};
        do @(posedge aclk); while (!s_tready);
        model_command(cmd, sel, val);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(20);
            gap        = $urandom_range(10, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold off until every due reply has arrived and the block has gone quiet
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (due_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic logic [tsmt_pkg::DATA_W-1:0] pick_value(input logic sel);
        int r;
        r = $urandom_range(99);
        if (r < 50) begin
            return tsmt_pkg::DATA_W'($urandom_range(15));
        end
        if (r < 70 && set_len[int'(sel)] > 0) begin
            return set_mem[int'(sel)][$urandom_range(set_len[int'(sel)] - 1)];
        end
        if (r < 80) begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return 31'h2AAA_AAAA;
                default: return 31'h5555_5555;
            endcase
        end
        return tsmt_pkg::DATA_W'($urandom);
    endfunction

    task automatic test_directed();
        send_word(tsmt_pkg::CMD_CHECK,  1'b0, '0);
        send_word(tsmt_pkg::CMD_DELETE, 1'b0, 31'd5);
        send_word(tsmt_pkg::CMD_ISECT,  1'b0, '1);
        send_word(tsmt_pkg::CMD_ADD,    1'b0, '0);
        send_word(tsmt_pkg::CMD_ADD,    1'b0, '1);
        send_word(tsmt_pkg::CMD_ADD,    1'b0, '0);
        send_word(tsmt_pkg::CMD_ADD,    1'b0, 31'd12345);
        send_word(tsmt_pkg::CMD_ADD,    1'b1, '1);
        send_word(tsmt_pkg::CMD_ADD,    1'b1, '0);
        send_word(tsmt_pkg::CMD_CHECK,  1'b0, '0);
        send_word(tsmt_pkg::CMD_CHECK,  1'b1, 31'd12345);
        send_word(tsmt_pkg::CMD_CHECK,  1'b0, '1);
        send_word(tsmt_pkg::CMD_ISECT,  1'b1, 31'h2AAA_AAAA);
        send_word(tsmt_pkg::CMD_DELETE, 1'b0, '0);
        send_word(tsmt_pkg::CMD_DELETE, 1'b0, 31'd99);
        send_word(tsmt_pkg::CMD_ISECT,  1'b0, 31'h5555_5555);
        send_word(tsmt_pkg::CMD_DELETE, 1'b1, '0);
        send_word(tsmt_pkg::CMD_DELETE, 1'b1, '1);
        send_word(tsmt_pkg::CMD_ISECT,  1'b1, 31'h5555_5555);
        send_word(tsmt_pkg::CMD_CHECK,  1'b1, '0);
    endtask

    // fill both sets to the brim; set B holds every value added here to A, so intersect yields a word for each
    task automatic test_fill();
        logic [tsmt_pkg::DATA_W-1:0] base;
        base = tsmt_pkg::DATA_W'($urandom_range(32'h7FFF_FFDF));
        while (set_len[0] < DEPTH) begin
            send_word(tsmt_pkg::CMD_ADD, 1'b0, base + tsmt_pkg::DATA_W'(set_len[0]));
        end
        send_word(tsmt_pkg::CMD_ADD, 1'b0, pick_value(1'b0));
        while (set_len[1] < DEPTH) begin
            send_word(tsmt_pkg::CMD_ADD, 1'b1,
                      base + tsmt_pkg::DATA_W'(DEPTH - 1 - set_len[1]));
        end
        send_word(tsmt_pkg::CMD_ADD, 1'b1, pick_value(1'b1));
        send_word(tsmt_pkg::CMD_ISECT, 1'b0, pick_value(1'b0));
        send_word(tsmt_pkg::CMD_DELETE, 1'b0, base);
        send_word(tsmt_pkg::CMD_DELETE, 1'b1, base + tsmt_pkg::DATA_W'(DEPTH / 2));
        send_word(tsmt_pkg::CMD_CHECK, 1'b1, base + tsmt_pkg::DATA_W'(DEPTH / 2));
        send_word(tsmt_pkg::CMD_ISECT, 1'b1, pick_value(1'b1));
    endtask

    // alternate shrinking and growing phases so the set sizes move both down and up
    task automatic test_random();
        int                         r;
        logic [tsmt_pkg::CMD_W-1:0] cmd;
        logic                       sel;
        for (int k = 0; k < 92; k++) begin
            r = $urandom_range(99);
            if ((k / 20) % 2 == 0) begin
                cmd = r < 20 ? tsmt_pkg::CMD_ADD : r < 40 ? tsmt_pkg::CMD_CHECK :
                      r < 85 ? tsmt_pkg::CMD_DELETE : tsmt_pkg::CMD_ISECT;
            end else begin
                cmd = r < 45 ? tsmt_pkg::CMD_ADD : r < 65 ? tsmt_pkg::CMD_CHECK :
                      r < 85 ? tsmt_pkg::CMD_DELETE : tsmt_pkg::CMD_ISECT;
            end
            sel = 1'($urandom_range(1));
            send_word(cmd, sel, pick_value(sel));
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d replies still due", cycle_count,
                 due_replies.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        set_len[0] = 0;
        set_len[1] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        wait_drained();
        test_fill();
        wait_drained();
        test_random();
        wait_drained();
        $display("sent %0d command words, checked %0d reply words", words_sent, replies_seen);
        $display("intersection words %0d, full replies %0d, mismatches %0d",
                 common_seen, full_seen, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
